// File: design/tcg_pkg.sv
package tcg_pkg;

    // Character codes with special meaning
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] SUBST_CODE = 8'h3F;  // '?'
    localparam logic [7:0] CODE_LIMIT = 8'h80;

    // Cells are eight pixels wide
    localparam int CELL_SHIFT = 3;

    // Input commands
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Result kinds
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PITCH       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BPP         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_COLS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_ROWS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_H     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_COUNT = 3'd5;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [15:0] pitch;
        logic [3:0]  pixel_stride;
        logic [7:0]  text_columns;
        logic [7:0]  text_rows;
        logic [5:0]  glyph_height;
        logic [9:0]  glyph_count;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // write one font row
        logic cr;           // return column
        logic start;        // latch a put character
        logic mul1;         // first multiply step, fetch glyph row 0
        logic mul2;         // second multiply step, update cursor
        logic emit_row;     // push one pixel row word
        logic emit_scroll;  // push the scroll word
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_load;
        logic in_cr;
        logic is_lf;        // latched character was LF
        logic scroll;       // this character scrolls the screen
        logic row_last;     // current glyph row is the final one
        logic out_free;     // output register can take a word
    } dp_status_t;

endpackage

// File: design/tcg_glyph_ram.sv
module tcg_glyph_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/tcg_ctrl.sv
module tcg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tcg_pkg::dp_status_t   status,
    output tcg_pkg::dp_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL1   = 5'b00010,
        S_MUL2   = 5'b00100,
        S_ROW    = 5'b01000,
        S_SCROLL = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (status.in_load) begin
                        cmd.load = 1'b1;
                    end else if (status.in_cr) begin
                        cmd.cr = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2 = 1'b1;
                priority if (!status.is_lf) begin
                    state_next = S_ROW;
                end else if (status.scroll) begin
                    state_next = S_SCROLL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ROW: begin
                if (status.out_free) begin
                    cmd.emit_row = 1'b1;
                    if (status.row_last) begin
                        state_next = status.scroll ? S_SCROLL : S_IDLE;
                    end
                end
            end
            S_SCROLL: begin
                if (status.out_free) begin
                    cmd.emit_scroll = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/tcg_dpath.sv
module tcg_dpath #(
    parameter int MAX_GLYPHS     = 128,
    parameter int MAX_GLYPH_ROWS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcg_pkg::cfg_t        cfg,
    input  logic                 s_cmd,
    input  logic [7:0]           s_char_code,
    input  logic [4:0]           s_glyph_row,
    input  logic [7:0]           s_row_bits,
    input  tcg_pkg::dp_cmd_t     cmd,
    output tcg_pkg::dp_status_t  status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [31:0]          m_address,
    output logic [31:0]          m_length,
    output logic [7:0]           m_pixel_bits,
    output logic                 m_last
);

    localparam int DEPTH = MAX_GLYPHS * MAX_GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = $clog2(MAX_GLYPHS);
    localparam int YW    = $clog2(MAX_GLYPH_ROWS);
    localparam logic [9:0] GLYPH_LIM = 10'(MAX_GLYPHS);
    localparam logic [5:0] ROWS_LIM  = 6'(MAX_GLYPH_ROWS);

    // Input decode
    logic          code_ok;
    logic [7:0]    code_sub;
    logic          load_ok;
    logic [AW-1:0] load_addr;
    logic [AW-1:0] put_base;

    assign code_ok = (s_char_code != 8'd0) && (s_char_code < tcg_pkg::CODE_LIMIT)
                  && ({2'b00, s_char_code} < cfg.glyph_count)
                  && ({2'b00, s_char_code} < GLYPH_LIM);
    assign code_sub  = code_ok ? s_char_code : tcg_pkg::SUBST_CODE;
    assign load_ok   = ({2'b00, s_char_code} < GLYPH_LIM) && ({1'b0, s_glyph_row} < ROWS_LIM);
    assign load_addr = AW'(GW'(s_char_code) * MAX_GLYPH_ROWS) + AW'(s_glyph_row);
    assign put_base  = AW'(GW'(code_sub) * MAX_GLYPH_ROWS);

    // Effective sizes
    logic [5:0] h_eff;
    logic [7:0] rows_eff;
    logic [7:0] cols_eff;

    always_comb begin
        priority if (cfg.glyph_height == 6'd0) begin
            h_eff = 6'd1;
        end else if (cfg.glyph_height > ROWS_LIM) begin
            h_eff = ROWS_LIM;
        end else begin
            h_eff = cfg.glyph_height;
        end
    end

    assign rows_eff = (cfg.text_rows == 8'd0) ? 8'd1 : cfg.text_rows;
    assign cols_eff = (cfg.text_columns == 8'd0) ? 8'd1 : cfg.text_columns;

    // Cursor and per-character registers
    logic [7:0]    col_reg, col_next;
    logic [7:0]    row_reg, row_next;
    logic [AW-1:0] base_reg;
    logic          is_lf_reg;
    logic          wrap_reg;
    logic          scroll_reg;
    logic [YW-1:0] hm1_reg;
    logic [YW-1:0] y_reg;
    logic [13:0]   rowh_reg;
    logic [14:0]   basex_reg;
    logic [21:0]   line_bytes_reg;
    logic [31:0]   line_addr_reg;
    logic [31:0]   scroll_len_reg;

    logic [7:0] col_inc;
    logic [7:0] row_inc;
    logic       wrap;
    logic       over;

    assign col_inc = col_reg + 8'd1;
    assign row_inc = row_reg + 8'd1;
    assign wrap    = (col_inc >= cols_eff);
    assign over    = (row_inc >= rows_eff);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.cr) begin
            col_next = 8'd0;
        end
        if (cmd.mul2) begin
            if (is_lf_reg || wrap_reg) begin
                col_next = 8'd0;
                row_next = scroll_reg ? (rows_eff - 8'd1) : row_inc;
            end else begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 8'd0;
            row_reg <= 8'd0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            base_reg  <= put_base;
            is_lf_reg <= (code_sub == tcg_pkg::CODE_LF);
        end
        if (cmd.mul1) begin
            wrap_reg       <= wrap;
            scroll_reg     <= (is_lf_reg || wrap) && over;
            hm1_reg        <= YW'(h_eff - 6'd1);
            y_reg          <= '0;
            rowh_reg       <= 14'(row_reg) * 14'(h_eff);
            basex_reg      <= {12'(col_reg) * 12'(cfg.pixel_stride), 3'b000};
            line_bytes_reg <= 22'(h_eff) * 22'(cfg.pitch);
        end
        if (cmd.mul2) begin
            line_addr_reg  <= 32'(rowh_reg) * 32'(cfg.pitch) + 32'(basex_reg);
            scroll_len_reg <= 32'(rows_eff - 8'd1) * 32'(line_bytes_reg);
        end
        if (cmd.emit_row) begin
            line_addr_reg <= line_addr_reg + 32'(cfg.pitch);
            y_reg         <= y_reg + YW'(1);
        end
    end

    // Glyph store: fetch row 0 in the first multiply step, then prefetch
    // the next row each time a row word leaves.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          row_last;

    assign row_last = (y_reg == hm1_reg);
    assign rd_en    = cmd.mul1 || (cmd.emit_row && !row_last);
    assign rd_addr  = cmd.mul1 ? base_reg : base_reg + AW'(YW'(y_reg + YW'(1)));

    tcg_glyph_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.load && load_ok),
        .wr_addr (load_addr),
        .wr_data (s_row_bits),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register
    logic m_valid_reg;
    logic kind_reg;
    logic [31:0] addr_reg;
    logic [31:0] len_reg;
    logic [7:0]  bits_reg;
    logic        last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_row || cmd.emit_scroll) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_row) begin
            kind_reg <= tcg_pkg::KIND_ROW;
            addr_reg <= line_addr_reg;
            len_reg  <= 32'd0;
            bits_reg <= rd_data;
            last_reg <= row_last && !scroll_reg;
        end else if (cmd.emit_scroll) begin
            kind_reg <= tcg_pkg::KIND_SCROLL;
            addr_reg <= 32'(line_bytes_reg);
            len_reg  <= scroll_len_reg;
            bits_reg <= 8'd0;
            last_reg <= 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_address    = addr_reg;
    assign m_length     = len_reg;
    assign m_pixel_bits = bits_reg;
    assign m_last       = last_reg;

    assign status.in_load  = (s_cmd == tcg_pkg::CMD_LOAD);
    assign status.in_cr    = (code_sub == tcg_pkg::CODE_CR);
    assign status.is_lf    = is_lf_reg;
    assign status.scroll   = scroll_reg;
    assign status.row_last = row_last;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// File: design/text_console_glyph_renderer.sv
// Font load and CR give no result word. A printed character gives one row word per
//   glyph row from the row loop over the glyph store port, then a scroll word if it
//   scrolls the screen; LF gives only a scroll word, if it scrolls. Words wait while
//   the output is stalled, and no new input is taken until the item is done.
//   One item is worked at a time.
// Reset: synchronous, active low; resets cursor, controller, output valid and config.
//   The glyph store is not cleared; unloaded rows read as garbage.
module text_console_glyph_renderer #(
    parameter int MAX_GLYPHS     = 128,
    parameter int MAX_GLYPH_ROWS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [tcg_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [tcg_pkg::CFG_DATA_W-1:0] cfg_data,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [7:0]                     s_char_code,
    input  logic [4:0]                     s_glyph_row,
    input  logic [7:0]                     s_row_bits,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_kind,
    output logic [31:0]                    m_address,
    output logic [31:0]                    m_length,
    output logic [7:0]                     m_pixel_bits,
    output logic                           m_last
);

    // Configuration registers; hold their value until rewritten.
    tcg_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                tcg_pkg::REG_PITCH:       cfg_next.pitch           = cfg_data;
                tcg_pkg::REG_BPP:         cfg_next.pixel_stride    = cfg_data[3:0];
                tcg_pkg::REG_TEXT_COLS:   cfg_next.text_columns    = cfg_data[7:0];
                tcg_pkg::REG_TEXT_ROWS:   cfg_next.text_rows       = cfg_data[7:0];
                tcg_pkg::REG_GLYPH_H:     cfg_next.glyph_height    = cfg_data[5:0];
                tcg_pkg::REG_GLYPH_COUNT: cfg_next.glyph_count     = cfg_data[9:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch           <= 16'd4096;
            cfg_reg.pixel_stride    <= 4'd4;
            cfg_reg.text_columns    <= 8'd128;
            cfg_reg.text_rows       <= 8'd48;
            cfg_reg.glyph_height    <= 6'd16;
            cfg_reg.glyph_count     <= 10'd256;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Controller sequences setup, row loop and scroll; datapath does the
    // address math, owns the cursor, the glyph store and the output word.
    tcg_pkg::dp_cmd_t    dp_cmd;
    tcg_pkg::dp_status_t dp_status;

    tcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    tcg_dpath #(
        .MAX_GLYPHS     (MAX_GLYPHS),
        .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_cmd        (s_cmd),
        .s_char_code  (s_char_code),
        .s_glyph_row  (s_glyph_row),
        .s_row_bits   (s_row_bits),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_address    (m_address),
        .m_length     (m_length),
        .m_pixel_bits (m_pixel_bits),
        .m_last       (m_last)
    );

endmodule

// File: design/tcg_checker.sv
module tcg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [31:0] m_address,
    input logic [31:0] m_length,
    input logic [7:0]  m_pixel_bits,
    input logic        m_last
);

    // Output word holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_address) && $stable(m_kind)
            && $stable(m_pixel_bits) && $stable(m_last))
    else $error("stalled output word changed");

    // Scroll word always ends its character and carries no pixels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == tcg_pkg::KIND_SCROLL) |-> m_last && (m_pixel_bits == 8'd0))
    else $error("scroll word malformed");

    // Row writes carry zero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == tcg_pkg::KIND_ROW) |-> (m_length == 32'd0))
    else $error("row word with nonzero length");

    // Reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("output valid after reset");

endmodule

bind text_console_glyph_renderer tcg_checker u_tcg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_address    (m_address),
    .m_length     (m_length),
    .m_pixel_bits (m_pixel_bits),
    .m_last       (m_last)
);

// File: sim/tb.sv
module tb;

    localparam int GLYPHS       = 128;
    localparam int GLYPH_ROWS   = 32;
    localparam int unsigned CELL_PIXELS = 1 << tcg_pkg::CELL_SHIFT;
    // Give the block time to finish a word that was accepted but gives no result
    // before touching registers.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RUN_LIMIT     = 6_000_000;
    // Glyphs the random part draws with; the last two listed are kept for tall fonts.
    localparam logic [6*8-1:0] GLYPH_POOL = {8'h55, 8'h20, 8'h7F, 8'h41, 8'h01,
                                             tcg_pkg::SUBST_CODE};

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [31:0] length;
        logic [7:0]  pixel_bits;
        logic        last;
    } fb_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [tcg_pkg::REG_IDX_W-1:0]  cfg_index = tcg_pkg::REG_PITCH;
    logic [tcg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = tcg_pkg::CMD_PUT;
    logic [7:0]  s_char_code = 8'h00;
    logic [4:0]  s_glyph_row = 5'd0;
    logic [7:0]  s_row_bits = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [31:0] m_address;
    logic [31:0] m_length;
    logic [7:0]  m_pixel_bits;
    logic        m_last;

    // Shadow of the console: registers, cursor and font as the block should hold them
    tcg_pkg::cfg_t console_cfg;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [7:0]  font_rows [GLYPHS][GLYPH_ROWS];
    bit          row_loaded [GLYPHS][GLYPH_ROWS];
    fb_word_t    fb_words_due [$];

    int          error_count = 0;
    int          items_sent = 0;
    int          words_checked = 0;
    int          scrolls_checked = 0;
    int          settings_used = 0;
    int          glyph_pool_used = 6;
    bit          tx_idle_on = 1'b1;
    logic        rx_idle_on = 1'b1;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          rx_wait = 0;
    fb_word_t    chk_want;
    fb_word_t    chk_got;

    text_console_glyph_renderer #(
        .MAX_GLYPHS     (GLYPHS),
        .MAX_GLYPH_ROWS (GLYPH_ROWS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_char_code  (s_char_code),
        .s_glyph_row  (s_glyph_row),
        .s_row_bits   (s_row_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_address    (m_address),
        .m_length     (m_length),
        .m_pixel_bits (m_pixel_bits),
        .m_last       (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #RUN_LIMIT;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------

    // Zero height acts as one row, anything past the store saturates.
    function automatic int unsigned glyph_rows_eff();
        if (console_cfg.glyph_height == 6'd0) return 1;
        if (console_cfg.glyph_height > GLYPH_ROWS) return GLYPH_ROWS;
        return 32'(console_cfg.glyph_height);
    endfunction

    // Swap unprintable codes for '?'; this runs before LF and CR are decoded,
    // so a high-bit LF or CR is drawn as '?'.
    function automatic logic [7:0] shown_glyph(input logic [7:0] code);
        if (code == 8'h00 || code >= tcg_pkg::CODE_LIMIT
                || {2'b00, code} >= console_cfg.glyph_count || code >= GLYPHS)
            return tcg_pkg::SUBST_CODE;
        return code;
    endfunction

    // Step the cursor to the next line; queue a scroll word when it falls off
    // the bottom and pin it to the last row. Return 1 if a scroll was queued.
    function automatic bit advance_line();
        int unsigned rows;
        int unsigned line_bytes;
        fb_word_t    w;
        rows = (console_cfg.text_rows == 8'd0) ? 1 : console_cfg.text_rows;
        cur_col = 8'd0;
        cur_row = cur_row + 8'd1;
        if (cur_row >= rows) begin
            line_bytes   = glyph_rows_eff() * console_cfg.pitch;
            w.kind       = tcg_pkg::KIND_SCROLL;
            w.address    = line_bytes;
            w.length     = (rows - 1) * line_bytes;
            w.pixel_bits = 8'h00;
            w.last       = 1'b0;
            fb_words_due.push_back(w);
            cur_row = 8'(rows - 1);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted input word and queue the framebuffer words it causes.
    function automatic void console_step(input logic cmd, input logic [7:0] code,
                                         input logic [4:0] grow, input logic [7:0] bits);
        logic [7:0]  g;
        int unsigned h;
        int unsigned base_x;
        int unsigned base_y;
        fb_word_t    w;
        if (cmd == tcg_pkg::CMD_LOAD) begin
            // out-of-range glyph indexes are dropped
            if (code < GLYPHS) begin
                font_rows[code][grow]  = bits;
                row_loaded[code][grow] = 1'b1;
            end
            return;
        end
        g = shown_glyph(code);
        if (g == tcg_pkg::CODE_LF) begin
            if (advance_line()) begin
                w = fb_words_due.pop_back();
                w.last = 1'b1;
                fb_words_due.push_back(w);
            end
            return;
        end
        if (g == tcg_pkg::CODE_CR) begin
            cur_col = 8'd0;
            return;
        end
        h      = glyph_rows_eff();
        base_x = cur_col * CELL_PIXELS * console_cfg.pixel_stride;
        base_y = cur_row * h;
        for (int unsigned y = 0; y < h; y++) begin
            w.kind       = tcg_pkg::KIND_ROW;
            w.address    = (base_y + y) * console_cfg.pitch + base_x;
            w.length     = 32'd0;
            w.pixel_bits = font_rows[g][y];
            w.last       = 1'b0;
            fb_words_due.push_back(w);
        end
        cur_col = cur_col + 8'd1;
        if (cur_col >= ((console_cfg.text_columns == 8'd0) ? 8'd1 : console_cfg.text_columns))
            void'(advance_line());
        w = fb_words_due.pop_back();
        w.last = 1'b1;
        fb_words_due.push_back(w);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one input word, hold it until taken, then maybe drop valid a while.
    task automatic send_word(input logic cmd, input logic [7:0] code,
                             input logic [4:0] grow, input logic [7:0] bits);
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_char_code <= code;
        s_glyph_row <= grow;
        s_row_bits  <= bits;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        console_step(cmd, code, grow, bits);
        items_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Print a character; first load any glyph row it would read that was
    // never written, so the store is only read where it holds real data.
    task automatic put_char(input logic [7:0] code);
        logic [7:0]  g;
        int unsigned h;
        g = shown_glyph(code);
        if (g != tcg_pkg::CODE_LF && g != tcg_pkg::CODE_CR) begin
            h = glyph_rows_eff();
            for (int r = 0; r < h; r++)
                if (!row_loaded[g][r])
                    send_word(tcg_pkg::CMD_LOAD, g, r[4:0], 8'($urandom_range(0, 255)));
        end
        send_word(tcg_pkg::CMD_PUT, code, 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)));
    endtask

    // Drop valid, wait for every expected word, then let a silent item finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (fb_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; the enable is left high for the caller to drop.
    task automatic cfg_cycle(input logic [tcg_pkg::REG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            tcg_pkg::REG_PITCH:       console_cfg.pitch           = data;
            tcg_pkg::REG_BPP:         console_cfg.pixel_stride    = data[3:0];
            tcg_pkg::REG_TEXT_COLS:   console_cfg.text_columns    = data[7:0];
            tcg_pkg::REG_TEXT_ROWS:   console_cfg.text_rows       = data[7:0];
            tcg_pkg::REG_GLYPH_H:     console_cfg.glyph_height    = data[5:0];
            tcg_pkg::REG_GLYPH_COUNT: console_cfg.glyph_count     = data[9:0];
            default: ;
        endcase
    endtask

    task automatic program_console(input logic [15:0] pitch_v, input logic [3:0] bpp_v,
                                   input logic [7:0] cols_v, input logic [7:0] rows_v,
                                   input logic [5:0] height_v, input logic [9:0] count_v);
        cfg_cycle(tcg_pkg::REG_PITCH, pitch_v);
        cfg_cycle(tcg_pkg::REG_BPP, {12'd0, bpp_v});
        cfg_cycle(tcg_pkg::REG_TEXT_COLS, {8'd0, cols_v});
        cfg_cycle(tcg_pkg::REG_TEXT_ROWS, {8'd0, rows_v});
        cfg_cycle(tcg_pkg::REG_GLYPH_H, {10'd0, height_v});
        cfg_cycle(tcg_pkg::REG_GLYPH_COUNT, {6'd0, count_v});
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed text from a small glyph set with fresh font rows
    // mixed in, plus line control, unprintable codes and stray loads.
    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            send_word(tcg_pkg::CMD_LOAD, 8'($urandom_range(0, 255)),
                      5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        else if (pick < 20)
            put_char(tcg_pkg::CODE_LF);
        else if (pick < 25)
            put_char(tcg_pkg::CODE_CR);
        else if (pick < 33)
            put_char(8'($urandom_range(128, 255)));
        else if (pick < 36)
            put_char(8'h00);
        else if (pick < 40 && glyph_pool_used > 2)
            put_char(8'($urandom_range(1, 127)));
        else
            put_char(GLYPH_POOL[8*$urandom_range(0, glyph_pool_used - 1) +: 8]);
    endtask

    task automatic run_phase(input logic [15:0] pitch_v, input logic [3:0] bpp_v,
                             input logic [7:0] cols_v, input logic [7:0] rows_v,
                             input logic [5:0] height_v, input logic [9:0] count_v,
                             input int pool, input int n);
        settle();
        program_console(pitch_v, bpp_v, cols_v, rows_v, height_v, count_v);
        glyph_pool_used = pool;
        repeat (n) random_item();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            rx_wait  <= HOLD_CYCLES - 1;
            m_ready  <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            m_ready  <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_wait  <= $urandom_range(0, 7);
            m_ready  <= 1'b0;
        end else begin
            m_ready  <= 1'b1;
        end
    end

    // Compare each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chk_got.kind       = m_kind;
            chk_got.address    = m_address;
            chk_got.length     = m_length;
            chk_got.pixel_bits = m_pixel_bits;
            chk_got.last       = m_last;
            if (fb_words_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word kind=%0d addr=%h len=%h bits=%h last=%0d",
                         $time, chk_got.kind, chk_got.address, chk_got.length,
                         chk_got.pixel_bits, chk_got.last);
            end else begin
                chk_want = fb_words_due.pop_front();
                if (chk_got.kind !== chk_want.kind || chk_got.address !== chk_want.address
                        || chk_got.length !== chk_want.length
                        || chk_got.pixel_bits !== chk_want.pixel_bits
                        || chk_got.last !== chk_want.last) begin
                    error_count++;
                    $display({"%0t: word %0d mismatch: expected kind=%0d addr=%h len=%h ",
                              "bits=%h last=%0d, got kind=%0d addr=%h len=%h bits=%h last=%0d"},
                             $time, words_checked, chk_want.kind, chk_want.address,
                             chk_want.length, chk_want.pixel_bits, chk_want.last,
                             chk_got.kind, chk_got.address, chk_got.length,
                             chk_got.pixel_bits, chk_got.last);
                end
            end
            words_checked++;
            if (chk_got.kind == tcg_pkg::KIND_SCROLL) scrolls_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Print with the registers as reset left them: 16-row glyphs, 4096-byte
    // pitch, 4 bytes per pixel. Unprintable codes pull in '?'.
    task automatic test_reset_values();
        put_char(8'hC3);
        put_char(8'h00);
        put_char(tcg_pkg::CODE_CR);
        put_char(tcg_pkg::CODE_LF);
    endtask

    // Small screen so that wrap and scroll come quickly.
    task automatic test_special_codes();
        settle();
        program_console(16'd160, 4'd2, 8'd3, 8'd2, 6'd2, 10'd100);
        send_word(tcg_pkg::CMD_LOAD, tcg_pkg::SUBST_CODE, 5'd0, 8'hA5);
        send_word(tcg_pkg::CMD_LOAD, tcg_pkg::SUBST_CODE, 5'd1, 8'h5A);
        send_word(tcg_pkg::CMD_LOAD, 8'h50, 5'd0, 8'hFF);
        send_word(tcg_pkg::CMD_LOAD, 8'h50, 5'd1, 8'h81);
        // alias of glyph 0x50 above the store: must be dropped
        send_word(tcg_pkg::CMD_LOAD, 8'hD0, 5'd0, 8'h00);
        send_word(tcg_pkg::CMD_LOAD, 8'h50, 5'd31, 8'h3C);
        put_char(8'h50);
        put_char(8'h00);
        // at or above the glyph count; also wraps the column
        put_char(8'h64);
        put_char(8'hFF);
        put_char(tcg_pkg::CODE_CR);
        put_char(8'h80);
        put_char(8'h7F);
        // two line feeds off the bottom: scroll twice
        put_char(tcg_pkg::CODE_LF);
        put_char(tcg_pkg::CODE_LF);
        // high-bit LF and CR are drawn, not obeyed
        put_char(8'h8A);
        put_char(8'h8D);
        put_char(8'h50);
    endtask

    task automatic test_config_sweep();
        run_phase(16'd1, 4'd1, 8'd1, 8'd1, 6'd1, 10'd64, 6, 10);
        run_phase(16'hFFFF, 4'd8, 8'd255, 8'd255, 6'd4, 10'd512, 6, 12);
        run_phase(16'd0, 4'd0, 8'd0, 8'd0, 6'd0, 10'd0, 6, 8);
        run_phase(16'd1234, 4'd15, 8'd5, 8'd3, 6'd63, 10'd1023, 2, 8);
        run_phase(16'd640, 4'd4, 8'd7, 8'd2, 6'd32, 10'd128, 2, 6);
        repeat (2)
            run_phase(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 8)),
                      8'($urandom_range(1, 20)), 8'($urandom_range(1, 6)),
                      6'($urandom_range(1, 8)), 10'($urandom_range(64, 512)),
                      6, 12);
    endtask

    // Hold the result side off for a long stretch while characters keep coming,
    // so the block backs up and drops s_ready.
    task automatic test_output_stall();
        settle();
        program_console(16'd4096, 4'd4, 8'd40, 8'd4, 6'd8, 10'd128);
        glyph_pool_used = 6;
        hold_req <= ~hold_req;
        repeat (12) put_char(GLYPH_POOL[8*$urandom_range(0, 5) +: 8]);
    endtask

    // Back-to-back words with both sides always ready.
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (16) random_item();
    endtask

    initial begin
        console_cfg.pitch           = 16'd4096;
        console_cfg.pixel_stride    = 4'd4;
        console_cfg.text_columns    = 8'd128;
        console_cfg.text_rows       = 8'd48;
        console_cfg.glyph_height    = 6'd16;
        console_cfg.glyph_count     = 10'd256;
        cur_col = 8'd0;
        cur_row = 8'd0;
        foreach (row_loaded[g, r]) row_loaded[g][r] = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_special_codes();
        test_config_sweep();
        test_output_stall();
        test_full_rate();

        s_valid <= 1'b0;
        while (fb_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d input words across %0d register settings, one %0d-cycle output hold",
                 items_sent, settings_used + 1, HOLD_CYCLES);
        $display("Checked %0d framebuffer words, %0d of them scroll commands",
                 words_checked, scrolls_checked);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: text_console_glyph_renderer.f
design/tcg_pkg.sv
design/tcg_glyph_ram.sv
design/tcg_ctrl.sv
design/tcg_dpath.sv
design/text_console_glyph_renderer.sv
design/tcg_checker.sv
sim/tb.sv
